[src/rbsi_pkg.sv]
// Package for the ray/box slab intersection block: widths, constants, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rbsi_pkg;
  localparam int unsigned FracBits = 16;
  localparam int unsigned NumWidth = 49;  // 33-bit distance scaled by 2^FracBits
  localparam int unsigned DenWidth = 32;
  localparam int unsigned DivSteps = NumWidth;
  localparam logic signed [31:0] TMin = 32'sh8000_0000;
  localparam logic signed [31:0] TMax = 32'sh7fff_ffff;

  typedef struct packed {
    logic [2:0][31:0] start;
    logic [2:0][31:0] dir;
    logic [2:0][31:0] lo;
    logic [2:0][31:0] hi;
  } ray_box_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] t_near;
    logic [31:0] t_far;
  } result_t;

  // Per-axis flags that travel beside the divider.
  typedef struct packed {
    logic in_box;     // start within whole box
    logic [2:0] zero_dir;
    logic [2:0] in_slab;
  } axis_flags_t;
endpackage
`default_nettype wire

[src/rbsi_if.sv]
// Valid/ready channel interface for the ray/box block.
// Depends on rbsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rbsi_in_if import rbsi_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [31:0] start_x, start_y, start_z, dir_x, dir_y, dir_z;
  logic signed [31:0] box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z;
  modport source (output valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                  box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
                output ready);
endinterface

interface rbsi_out_if ();
  logic valid;
  logic ready;
  logic hit;
  logic signed [31:0] t_near, t_far;
  modport source (output valid, hit, t_near, t_far, input ready);
  modport sink (input valid, hit, t_near, t_far, output ready);
endinterface
`default_nettype wire

[src/ray_box_slab_intersect.sv]
// Top level of the ray/box slab intersection block.
// Depends on rbsi_pkg, rbsi_if and rbsi_core.
//
// Channel  Dir  Payload
// in_i     in   start, dir, box_lo, box_hi (x,y,z), signed Q16.16
// out_o    out  hit, t_near, t_far
//
// The pipeline runs setup, 49 quotient-bit stages and a reduction stage; one
// transaction per cycle while the output does not stall. Six restoring dividers set the depth.
// Reset clears only the valid bits. A stall on the output freezes the
// whole pipeline; ready follows the output side, so nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_intersect import rbsi_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rbsi_in_if.sink   in_i,
  rbsi_out_if.source out_o
);
  logic en, vld;
  ray_box_t item;
  result_t res;

  // Advance whenever the output slot is empty or being drained.
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  assign item.start = {in_i.start_z, in_i.start_y, in_i.start_x};
  assign item.dir   = {in_i.dir_z, in_i.dir_y, in_i.dir_x};
  assign item.lo    = {in_i.box_lo_z, in_i.box_lo_y, in_i.box_lo_x};
  assign item.hi    = {in_i.box_hi_z, in_i.box_hi_y, in_i.box_hi_x};

  rbsi_core u_core (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid),
    .item_i(item), .valid_o(vld), .res_o(res)
  );

  assign out_o.valid  = vld;
  assign out_o.hit    = res.hit;
  assign out_o.t_near = res.t_near;
  assign out_o.t_far  = res.t_far;
endmodule
`default_nettype wire

[src/rbsi_div_stage.sv]
// One restoring-division step on the magnitudes of fixed-point slab quotients.
// Depends on rbsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbsi_div_stage import rbsi_pkg::*; (
  input  wire logic [NumWidth-1:0] rem_i,
  input  wire logic [NumWidth-1:0] quo_i,
  input  wire logic [DenWidth-1:0] den_i,
  output logic      [NumWidth-1:0] rem_o,
  output logic      [NumWidth-1:0] quo_o
);
  logic [NumWidth:0] shifted;
  logic [NumWidth:0] diff;
  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    shifted = {rem_i, quo_i[NumWidth-1]};
    diff    = shifted - {{(NumWidth+1-DenWidth){1'b0}}, den_i};
    if (!diff[NumWidth]) begin
      rem_o = diff[NumWidth-1:0];
      quo_o = {quo_i[NumWidth-2:0], 1'b1};
    end else begin
      rem_o = shifted[NumWidth-1:0];
      quo_o = {quo_i[NumWidth-2:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

[src/rbsi_core.sv]
// Pipelined slab test: setup, six parallel dividers, reduction.
// Depends on rbsi_pkg and rbsi_div_stage.
`timescale 1ns / 1ps
`default_nettype none
module rbsi_core import rbsi_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    en_i,
  input  wire logic    valid_i,
  input  wire ray_box_t item_i,
  output logic         valid_o,
  output result_t      res_o
);
  localparam int unsigned Depth = DivSteps + 2;
  localparam int unsigned NDiv = 6;

  // Stage 0: magnitudes and signs of every plane distance.
  logic [Depth-1:0] vld_q;
  axis_flags_t fl_q [DivSteps+1];
  logic [NDiv-1:0] neg_q [DivSteps+1];
  logic [DenWidth-1:0] den_q [DivSteps+1][NDiv];
  logic [NumWidth-1:0] rem_q [DivSteps+1][NDiv];
  logic [NumWidth-1:0] quo_q [DivSteps+1][NDiv];

  axis_flags_t fl_d;
  logic [NDiv-1:0] neg_d;
  logic [DenWidth-1:0] den_d [NDiv];
  logic [NumWidth-1:0] num_d [NDiv];

  always_comb begin
    logic signed [32:0] pdist;
    logic signed [31:0] d;
    logic [32:0] mag;
    fl_d.in_box = 1'b1;
    for (int a = 0; a < 3; a++) begin
      fl_d.in_slab[a] = !($signed(item_i.start[a]) < $signed(item_i.lo[a]) ||
                          $signed(item_i.start[a]) > $signed(item_i.hi[a]));
      fl_d.zero_dir[a] = (item_i.dir[a] == '0);
      if (!fl_d.in_slab[a]) fl_d.in_box = 1'b0;
    end
    for (int k = 0; k < NDiv; k++) begin
      d = $signed(item_i.dir[k % 3]);
      pdist = (k < 3) ? ($signed({item_i.lo[k % 3][31], item_i.lo[k % 3]}) -
                         $signed({item_i.start[k % 3][31], item_i.start[k % 3]}))
                      : ($signed({item_i.hi[k % 3][31], item_i.hi[k % 3]}) -
                         $signed({item_i.start[k % 3][31], item_i.start[k % 3]}));
      mag = pdist[32] ? 33'(-pdist) : 33'(pdist);
      num_d[k] = {mag, {FracBits{1'b0}}};
      den_d[k] = d[31] ? 32'(-d) : 32'(d);
      neg_d[k] = pdist[32] ^ d[31];
    end
  end

  // Pipeline registers; stage 1..DivSteps run one quotient bit each.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl_q[0]  <= fl_d;
      neg_q[0] <= neg_d;
      for (int k = 0; k < NDiv; k++) begin
        den_q[0][k] <= den_d[k];
        rem_q[0][k] <= '0;
        quo_q[0][k] <= num_d[k];
      end
    end
  end

  for (genvar s = 1; s <= DivSteps; s++) begin : g_step
    for (genvar k = 0; k < NDiv; k++) begin : g_lane
      logic [NumWidth-1:0] rem_n, quo_n;
      rbsi_div_stage u_step (
        .rem_i(rem_q[s-1][k]), .quo_i(quo_q[s-1][k]), .den_i(den_q[s-1][k]),
        .rem_o(rem_n), .quo_o(quo_n)
      );
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s][k] <= rem_n;
          quo_q[s][k] <= quo_n;
          den_q[s][k] <= den_q[s-1][k];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        fl_q[s]  <= fl_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  // Final stage: sign, saturate, order and narrow the interval.
  result_t res_d;
  always_comb begin
    logic signed [31:0] t [NDiv];
    logic signed [31:0] t1, t2, tn, tf;
    logic miss;
    for (int k = 0; k < NDiv; k++) begin
      if (neg_q[DivSteps][k])
        t[k] = (quo_q[DivSteps][k] > NumWidth'(33'h0_8000_0000)) ? TMin :
               32'(-quo_q[DivSteps][k]);
      else
        t[k] = (quo_q[DivSteps][k] > NumWidth'(33'h0_7fff_ffff)) ? TMax :
               32'(quo_q[DivSteps][k]);
    end
    t1 = '0;
    t2 = '0;
    tn = TMin;
    tf = TMax;
    miss = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (!miss) begin
        if (fl_q[DivSteps].zero_dir[a]) begin
          if (!fl_q[DivSteps].in_slab[a]) miss = 1'b1;
        end else begin
          t1 = (t[a] > t[a+3]) ? t[a+3] : t[a];
          t2 = (t[a] > t[a+3]) ? t[a] : t[a+3];
          if (t1 > tn) tn = t1;
          if (t2 < tf) tf = t2;
          if (tn > tf || tf < 0) miss = 1'b1;
        end
      end
    end
    res_d.hit    = fl_q[DivSteps].in_box || !miss;
    res_d.t_near = (fl_q[DivSteps].in_box || miss) ? '0 : tn;
    res_d.t_far  = (fl_q[DivSteps].in_box || miss) ? '0 : tf;
  end

  result_t res_q;
  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end
  assign valid_o = vld_q[DivSteps+1];
  assign res_o   = res_q;
endmodule
`default_nettype wire

[src/rbsi_checker.sv]
// Port-level checks for the ray/box block, bound to the top level.
// Depends on ray_box_slab_intersect and its rbsi_if ports.
`timescale 1ns / 1ps
`default_nettype none
module rbsi_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic hit,
  input wire logic [31:0] t_near,
  input wire logic [31:0] t_far
);
  // A miss carries zero distances.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !hit |-> t_near == '0 && t_far == '0) else $error("miss nonzero");
  // A hit never has near beyond far.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && hit |-> $signed(t_near) <= $signed(t_far)) else $error("order");
  // Input is taken whenever the output is free.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready) else $error("ready");
  // Stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(t_near) && $stable(t_far))
    else $error("hold");
endmodule

bind ray_box_slab_intersect rbsi_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready(in_i.ready), .out_valid(out_o.valid),
  .out_ready(out_o.ready), .hit(out_o.hit), .t_near(out_o.t_near), .t_far(out_o.t_far)
);
`default_nettype wire
